@@ hdl/bba_pkg.sv @@
// bba_pkg: shared types and constants of the block bitmap allocator
// request and response payload structs, mode and status codes, controller links
// no dependencies
`timescale 1ns / 1ps

package bba_pkg;

	localparam int BLK_W      = 12;
	localparam int CNT_W      = 13;
	localparam int MODE_W     = 2;
	localparam int STAT_W     = 2;
	localparam int WORD_BITS  = 64;
	localparam int BIT_IDX_W  = 6;
	localparam int WORD_IDX_W = BLK_W - BIT_IDX_W;
	localparam int CFG_IDX_W  = 1;
	localparam int MAP_BITS   = 4096;

	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLOCK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT      = 1'd1;

	localparam logic [BLK_W-1:0] FIRST_DATA_BLOCK_RST = 12'd64;
	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST      = 13'd4096;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BLK_W-1:0]  block_number;
	} req_t;

	typedef struct packed {
		logic [BLK_W-1:0]  granted_block;
		logic [STAT_W-1:0] status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic              load_req;
		logic              scan_start;
		logic              scan_step;
		logic              free_rd;
		logic              free_wr;
		logic              alloc_wr;
		logic              clear_map;
		logic              set_res;
		logic              res_grant;
		logic [STAT_W-1:0] res_status;
		logic              deliver;
	} bba_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              range_empty;
		logic              free_ok;
		logic              hit;
		logic              at_last;
		logic              out_free;
	} bba_stat_t;

endpackage

@@ hdl/bba_ctrl.sv @@
// bba_ctrl: sequencing state machine of the block bitmap allocator
// drives datapath commands, takes back datapath status; uses bba_pkg
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  bba_stat_t st,
	output bba_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_FREE_RD = 3'd3;
	localparam logic [2:0] S_FREE_WR = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.mode)
					MODE_ALLOC: begin
						if (st.range_empty) begin
							cmd.set_res    = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					MODE_FREE: begin
						if (st.free_ok) begin
							state_d = S_FREE_RD;
						end else begin
							cmd.set_res    = 1'b1;
							cmd.res_status = ST_RANGE;
							state_d        = S_DONE;
						end
					end
					MODE_CLEAR: begin
						cmd.clear_map  = 1'b1;
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_DONE;
						state_d        = S_DONE;
					end
					default: begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_DONE;
						state_d        = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				// one word evaluated per cycle while the next one is being read
				if (st.hit) begin
					cmd.alloc_wr   = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_grant  = 1'b1;
					cmd.res_status = ST_DONE;
					state_d        = S_DONE;
				end else if (st.at_last) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_FULL;
					state_d        = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d     = S_FREE_WR;
			end
			S_FREE_WR: begin
				cmd.free_wr    = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_status = ST_DONE;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/bba_datapath.sv @@
// bba_datapath: used-bit map memory, row valid bits, config registers,
// word search logic and response register; uses bba_pkg
`timescale 1ns / 1ps

module bba_datapath import bba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bba_cmd_t             cmd,
	output bba_stat_t            st,
	input  req_t                 req,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
	localparam int MW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CAP       = (MAP_BITS < 4096) ? MAP_BITS : 4096;

	logic [WORD_BITS-1:0]  map_q [MAP_WORDS];
	logic [MAP_WORDS-1:0]  row_valid_q;

	logic [BLK_W-1:0]      first_blk_q;
	logic [CNT_W-1:0]      blk_count_q;
	logic [MODE_W-1:0]     mode_q;
	logic [BLK_W-1:0]      blk_q;
	logic [WORD_IDX_W-1:0] ptr_q;

	logic [WORD_BITS-1:0]  rdata_s1;
	logic                  rvalid_s1;
	logic [WORD_IDX_W-1:0] addr_s1;
	logic                  scan_s1;

	logic [BLK_W-1:0]      res_blk_q;
	logic [STAT_W-1:0]     res_stat_q;
	logic                  out_valid_q;
	rsp_t                  out_q;

	logic [CNT_W-1:0]      lim;
	logic [CNT_W-1:0]      lim_m1;
	logic [WORD_IDX_W-1:0] last_word;
	logic [WORD_IDX_W-1:0] rd_word;
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  lo_mask;
	logic [WORD_BITS-1:0]  hi_mask;
	logic [WORD_BITS-1:0]  free_vec;
	logic [BIT_IDX_W-1:0]  hit_idx;
	logic [WORD_BITS-1:0]  wr_data;
	logic                  wr_en;

	// effective upper limit is the smaller of block count and map size
	assign lim       = (blk_count_q < CNT_W'(CAP)) ? blk_count_q : CNT_W'(CAP);
	assign lim_m1    = lim - 1'b1;
	assign last_word = lim_m1[BLK_W-1:BIT_IDX_W];

	assign rd_word = cmd.free_rd ? blk_q[BLK_W-1:BIT_IDX_W] : ptr_q;
	assign word    = rvalid_s1 ? rdata_s1 : '0;

	assign lo_mask = (addr_s1 == first_blk_q[BLK_W-1:BIT_IDX_W]) ?
		({WORD_BITS{1'b1}} << first_blk_q[BIT_IDX_W-1:0]) : {WORD_BITS{1'b1}};
	assign hi_mask = (addr_s1 == last_word) ?
		({WORD_BITS{1'b1}} >> (~lim_m1[BIT_IDX_W-1:0])) : {WORD_BITS{1'b1}};
	assign free_vec = ~word & lo_mask & hi_mask;

	always_comb begin
		hit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				hit_idx = BIT_IDX_W'(i);
			end
		end
	end

	assign wr_en   = cmd.alloc_wr | cmd.free_wr;
	assign wr_data = cmd.free_wr ?
		(word & ~(WORD_BITS'(1) << blk_q[BIT_IDX_W-1:0])) :
		(word | (WORD_BITS'(1) << hit_idx));

	assign st.mode        = mode_q;
	assign st.range_empty = ({1'b0, first_blk_q} >= lim);
	assign st.free_ok     = (blk_q != '0) && ({1'b0, blk_q} < lim);
	assign st.hit         = scan_s1 && (|free_vec);
	assign st.at_last     = scan_s1 && (addr_s1 == last_word);
	assign st.out_free    = !out_valid_q || !rsp_stall;

	// map memory: one read and one write port, read data registered
	always_ff @(posedge clk) begin
		rdata_s1 <= map_q[MW'(rd_word)];
		if (wr_en) begin
			map_q[MW'(addr_s1)] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_word;
		if (cmd.load_req) begin
			mode_q <= req.mode;
			blk_q  <= req.block_number;
		end
		if (cmd.scan_start) begin
			ptr_q <= first_blk_q[BLK_W-1:BIT_IDX_W];
		end else if (cmd.scan_step) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.set_res) begin
			res_stat_q <= cmd.res_status;
			res_blk_q  <= cmd.res_grant ? {addr_s1, hit_idx} : '0;
		end
		if (cmd.deliver) begin
			out_q.granted_block <= res_blk_q;
			out_q.status        <= res_stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_s1   <= 1'b0;
			scan_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			first_blk_q <= FIRST_DATA_BLOCK_RST;
			blk_count_q <= BLOCK_COUNT_RST;
		end else begin
			rvalid_s1 <= row_valid_q[MW'(rd_word)];
			scan_s1   <= cmd.scan_step;
			// a row that is not valid reads as all clear
			if (cmd.clear_map) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[MW'(addr_s1)] <= 1'b1;
			end
			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FIRST_DATA_BLOCK: first_blk_q <= cfg_data[BLK_W-1:0];
					REG_BLOCK_COUNT:      blk_count_q <= cfg_data;
					default:              ;
				endcase
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ hdl/block_bitmap_allocator_unit.sv @@
// block_bitmap_allocator_unit: first-fit allocator over a used-bit map of 64-bit words
// after decode, allocate on a non-empty range scans word by word, a valid free reads and
// rewrites its word, then every request waits in done until the output register is free
// one request at a time, the next at the earliest on the edge the response can first leave
// the response register lets the next request in while a response is stalled
// reset clears the map at once through per-word valid bits and loads the register defaults
`timescale 1ns / 1ps

module block_bitmap_allocator_unit import bba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	bba_cmd_t  cmd;
	bba_stat_t st;

	assign cfg_ready = 1'b1;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	bba_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for block_bitmap_allocator_unit
// keeps its own used-bit map and register copies to predict every response
// depends on bba_pkg and the allocator RTL
`timescale 1ns / 1ps

module tb;
	import bba_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int MAX_PRINTS = 40;
	localparam int TRAFFIC_PHASES = 12;
	localparam int PHASE_REQUESTS = 88;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;

	// predicted state of the allocator
	bit [MAP_BITS-1:0] used_map = '0;
	int unsigned       first_block = 32'(FIRST_DATA_BLOCK_RST);
	int unsigned       blocks_total = 32'(BLOCK_COUNT_RST);
	int                held_blocks[$];
	rsp_t              awaited_rsp[$];

	int   sender_idle_pct = 0;
	int   rsp_stall_pct = 0;
	int   error_count = 0;
	int   cycle_count = 0;
	int   n_requests = 0;
	int   n_checked = 0;
	int   n_granted = 0;
	int   n_full = 0;
	int   n_range = 0;
	int   n_cfg_writes = 0;
	rsp_t seen;
	rsp_t want;

	block_bitmap_allocator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d responses outstanding", cycle_count,
				awaited_rsp.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTS) begin
			$display("tb: mismatch at cycle %0d: %s", cycle_count, what);
		end
	endtask

	// first-fit search, free and clear applied to the local map
	function automatic rsp_t bitmap_apply(input req_t r);
		rsp_t        res;
		int unsigned lim;
		int unsigned b;
		int          k;
		bit          found;
		res = '0;
		found = 1'b0;
		lim = (blocks_total > MAP_BITS) ? MAP_BITS : blocks_total;
		case (r.mode)
			MODE_ALLOC: begin
				res.status = ST_FULL;
				for (b = first_block; b < lim && !found; b++) begin
					if (!used_map[b]) begin
						used_map[b] = 1'b1;
						held_blocks.push_back(b);
						res.granted_block = b[BLK_W-1:0];
						res.status = ST_DONE;
						found = 1'b1;
					end
				end
				if (found) n_granted++;
				else n_full++;
			end
			MODE_FREE: begin
				if (r.block_number != 0 && r.block_number < lim) begin
					used_map[r.block_number] = 1'b0;
					for (k = 0; k < held_blocks.size() && !found; k++) begin
						if (held_blocks[k] == r.block_number) begin
							held_blocks.delete(k);
							found = 1'b1;
						end
					end
				end else begin
					res.status = ST_RANGE;
					n_range++;
				end
			end
			MODE_CLEAR: begin
				used_map = '0;
				held_blocks.delete();
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen = rsp;
			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf("response with none outstanding: block %0d status %0d",
					seen.granted_block, seen.status));
			end else begin
				want = awaited_rsp.pop_front();
				n_checked++;
				if (seen.granted_block !== want.granted_block) begin
					report_mismatch($sformatf("granted_block %0d, predicted %0d",
						seen.granted_block, want.granted_block));
				end
				if (seen.status !== want.status) begin
					report_mismatch($sformatf("status %0d, predicted %0d", seen.status,
						want.status));
				end
			end
		end
	end

	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [BLK_W-1:0] blk);
		req_t r;
		r.mode = mode;
		r.block_number = blk;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		awaited_rsp.push_back(bitmap_apply(r));
		n_requests++;
	endtask

	// sender holds off until every request has been answered
	task automatic wait_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_FIRST_DATA_BLOCK) first_block = 32'(data[BLK_W-1:0]);
		else blocks_total = 32'(data);
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [CNT_W-1:0] first_val, input logic [CNT_W-1:0] count_val);
		wait_responses();
		write_reg(REG_FIRST_DATA_BLOCK, first_val);
		write_reg(REG_BLOCK_COUNT, count_val);
	endtask

	task automatic test_reset_defaults();
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, 12'hFFF);   // block number ignored on allocate
		send_request(MODE_FREE, 12'd64);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 12'd100);    // already clear
		send_request(MODE_FREE, 12'd0);      // block zero is never freed
		send_request(MODE_FREE, 12'hFFF);
		send_request(MODE_UNUSED, 12'hFFF);
		send_request(MODE_CLEAR, 12'hABC);
		send_request(MODE_ALLOC, '0);
	endtask

	task automatic test_register_extremes();
		// single block volume, block zero can be handed out
		set_regs(13'd0, 13'd1);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 12'd0);
		send_request(MODE_FREE, 12'd1);
		set_regs(13'd0, 13'd0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 12'd5);
		// index 0 keeps only the low 12 bits, count beyond the map is clipped
		set_regs(13'h1FFF, 13'h1FFF);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 12'hFFF);
		send_request(MODE_ALLOC, '0);
		set_regs(13'd100, 13'd100);
		send_request(MODE_ALLOC, '0);
		send_request(MODE_FREE, 12'd99);
		// window across a word boundary with a used block inside
		set_regs(13'd62, 13'd66);
		repeat (4) send_request(MODE_ALLOC, '0);
	endtask

	task automatic test_random_traffic();
		int               phase;
		int               i;
		int               pick;
		int               shape;
		logic [CNT_W-1:0] first_val;
		logic [CNT_W-1:0] count_val;
		logic [MODE_W-1:0] mode;
		logic [BLK_W-1:0] blk;
		for (phase = 0; phase < TRAFFIC_PHASES; phase++) begin
			shape = $urandom_range(2);
			if (shape == 0) begin
				// narrow window, fills up and reports full often
				first_val = CNT_W'($urandom_range(4095));
				count_val = CNT_W'(first_val + $urandom_range(80, 1));
			end else if (shape == 1) begin
				first_val = CNT_W'($urandom_range(200));
				count_val = CNT_W'($urandom_range(8191, 4096));
			end else begin
				first_val = CNT_W'($urandom);
				count_val = CNT_W'($urandom);
			end
			set_regs(first_val, count_val);
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 69;
					rsp_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					rsp_stall_pct = 69;
				end
				default: begin
					sender_idle_pct = 33;
					rsp_stall_pct = 33;
				end
			endcase
			for (i = 0; i < PHASE_REQUESTS; i++) begin
				if (i == PHASE_REQUESTS / 2) wait_responses();
				pick = $urandom_range(99);
				blk = BLK_W'($urandom);
				if (pick < 50) begin
					mode = MODE_ALLOC;
				end else if (pick < 80 && held_blocks.size() > 0) begin
					// free a block that is currently in use
					mode = MODE_FREE;
					blk = BLK_W'(held_blocks[$urandom_range(held_blocks.size() - 1)]);
				end else if (pick < 94) begin
					mode = MODE_FREE;
				end else if (pick < 97) begin
					mode = MODE_CLEAR;
				end else begin
					mode = MODE_UNUSED;
				end
				send_request(mode, blk);
			end
		end
		sender_idle_pct = 0;
		rsp_stall_pct = 0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		wait_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("tb: %0d of %0d requests answered, %0d register writes, four idling patterns",
			n_checked, n_requests, n_cfg_writes);
		$display("tb: predicted %0d grants, %0d full, %0d out-of-range frees",
			n_granted, n_full, n_range);
		if (error_count == 0 && awaited_rsp.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
